FILE: rtl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the circular list engine.
// ----------------------------------------------------------------------------
package cle_pkg;

  localparam int CapacityDefault = 32;
  localparam int DataBitsDefault = 32;
  localparam int OpBits          = 3;
  localparam int ValueBits       = 32;
  localparam int PosBits         = 7;
  localparam int StatusBits      = 2;
  localparam int LengthBits      = 7;

  typedef enum logic [OpBits-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_DEL_HEAD = 3'd3,
    OP_DEL_TAIL = 3'd4,
    OP_DEL_POS  = 3'd5,
    OP_DUMP     = 3'd6,
    OP_NOP      = 3'd7
  } op_t;

  typedef enum logic [StatusBits-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_WALK_WAIT,
    S_INSERT,
    S_UNLINK_RD,
    S_UNLINK,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic    latch;      // capture request
    logic    walk_start; // cursor to head, or tail with sel_tail
    logic    walk_step;  // cursor follows next link
    logic    rd_cursor;  // read links and value at cursor
    logic    do_insert;  // insert after cursor (or at end)
    logic    ins_end;    // insert at head or tail
    logic    ins_head;   // end insert becomes head
    logic    do_unlink;  // unlink cursor slot
    logic    sel_tail;   // cursor to tail
    logic    emit;       // load output register
    logic    emit_dump;  // output carries value
    logic    emit_last;
    status_t emit_status;
  } cle_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t                 op;
    logic [PosBits-1:0]  pos;
    logic [LengthBits-1:0] count;
    logic                full;
    logic                out_busy;
  } cle_sts_t;

endpackage

FILE: rtl/cle_req_if.sv
// ----------------------------------------------------------------------------
// cle_req_if / cle_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface cle_req_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 operation;
  logic signed [31:0]         value;
  logic [6:0]                 position;
  modport source (output valid, operation, value, position, input ready);
  modport sink (input valid, operation, value, position, output ready);
endinterface

interface cle_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic signed [31:0]         element_value;
  logic [6:0]                 list_length;
  logic                       last_result;
  modport source (output valid, status, element_value, list_length, last_result,
                  input ready);
  modport sink (input valid, status, element_value, list_length, last_result,
                output ready);
endinterface

FILE: rtl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Sequencer that walks links and steps each request through its updates.
// ----------------------------------------------------------------------------
module cle_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  cle_pkg::cle_sts_t sts,
  output cle_pkg::cle_cmd_t cmd
);
  import cle_pkg::*;

  state_t               state, state_next;
  logic [LengthBits-1:0] steps, steps_next;
  logic [LengthBits-1:0] done, done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      steps <= '0;
      done  <= '0;
    end else begin
      state <= state_next;
      steps <= steps_next;
      done  <= done_next;
    end
  end

  logic [LengthBits:0] pos_w;
  assign pos_w = {1'b0, sts.pos};

  always_comb begin
    state_next = state;
    steps_next = steps;
    done_next  = done;
    cmd        = '0;
    cmd.emit_status = ST_OK;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_RESULT;
        cmd.walk_start = 1'b1;
        unique case (sts.op)
          OP_INS_HEAD, OP_INS_TAIL: begin
            if (sts.full) cmd.emit_status = ST_FULL;
            else begin
              cmd.do_insert = 1'b1;
              cmd.ins_end   = 1'b1;
              cmd.ins_head  = (sts.op == OP_INS_HEAD);
            end
          end
          OP_INS_POS: begin
            if (sts.pos == '0 || pos_w > {1'b0, sts.count} + 8'd1)
              cmd.emit_status = ST_BADPOS;
            else if (sts.full) cmd.emit_status = ST_FULL;
            else if (sts.pos == 7'd1 || pos_w == {1'b0, sts.count} + 8'd1) begin
              cmd.do_insert = 1'b1;
              cmd.ins_end   = 1'b1;
              cmd.ins_head  = (sts.pos == 7'd1);
            end else begin
              steps_next = sts.pos - 7'd2;
              state_next = S_WALK;
            end
          end
          OP_DEL_HEAD, OP_DEL_TAIL: begin
            if (sts.count == '0) cmd.emit_status = ST_EMPTY;
            else begin
              cmd.sel_tail = (sts.op == OP_DEL_TAIL);
              state_next   = S_UNLINK_RD;
            end
          end
          OP_DEL_POS: begin
            if (sts.pos == '0 || sts.pos > sts.count) cmd.emit_status = ST_BADPOS;
            else begin
              steps_next = sts.pos - 7'd1;
              state_next = S_WALK;
            end
          end
          OP_DUMP: begin
            if (sts.count == '0) cmd.emit_status = ST_EMPTY;
            else begin
              done_next  = '0;
              state_next = S_DUMP_RD;
            end
          end
          default: cmd.emit_status = ST_OK;
        endcase
      end
      S_WALK: begin
        if (steps == '0) begin
          state_next = (sts.op == OP_DEL_POS) ? S_UNLINK_RD : S_INSERT;
        end else begin
          cmd.rd_cursor = 1'b1;
          state_next    = S_WALK_WAIT;
        end
      end
      S_WALK_WAIT: begin
        cmd.walk_step = 1'b1;
        steps_next    = steps - 7'd1;
        state_next    = S_WALK;
      end
      S_INSERT: begin
        cmd.rd_cursor = 1'b1;
        state_next    = S_UNLINK;
      end
      S_UNLINK_RD: begin
        cmd.rd_cursor = 1'b1;
        state_next    = S_UNLINK;
      end
      S_UNLINK: begin
        if (sts.op == OP_INS_POS) cmd.do_insert = 1'b1;
        else cmd.do_unlink = 1'b1;
        state_next = S_RESULT;
      end
      S_DUMP_RD: begin
        cmd.rd_cursor = 1'b1;
        state_next    = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (!sts.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.emit_dump = 1'b1;
          cmd.emit_last = (done + 7'd1 == sts.count);
          cmd.walk_step = 1'b1;
          done_next     = done + 7'd1;
          state_next    = (done + 7'd1 == sts.count) ? S_IDLE : S_DUMP_RD;
        end
      end
      S_RESULT: begin
        state_next = S_RESULT;
      end
      default: state_next = S_IDLE;
    endcase
    // status results are emitted by the datapath from its latched status
    if (state == S_RESULT && !sts.out_busy) begin
      cmd.emit      = 1'b1;
      cmd.emit_last = 1'b1;
      state_next    = S_IDLE;
    end
  end
endmodule

FILE: rtl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Slot pool, link memories, free stack and result register.
// ----------------------------------------------------------------------------
module cle_datapath #(
  parameter int CAPACITY  = cle_pkg::CapacityDefault,
  parameter int DATA_BITS = cle_pkg::DataBitsDefault
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [cle_pkg::OpBits-1:0]      operation,
  input  logic signed [cle_pkg::ValueBits-1:0] value,
  input  logic [cle_pkg::PosBits-1:0]     position,
  input  cle_pkg::cle_cmd_t               cmd,
  output cle_pkg::cle_sts_t               sts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [cle_pkg::StatusBits-1:0]  status,
  output logic signed [cle_pkg::ValueBits-1:0] element_value,
  output logic [cle_pkg::LengthBits-1:0]  list_length,
  output logic                            last_result
);
  import cle_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [DATA_BITS-1:0] vmem [CAPACITY];
  logic [SW-1:0]        nmem [CAPACITY];
  logic [SW-1:0]        pmem [CAPACITY];
  logic [SW-1:0]        fmem [CAPACITY];

  op_t                  op;
  logic [DATA_BITS-1:0] val;
  logic [PosBits-1:0]   pos;
  logic [CW-1:0]        free_top, fresh_next, count;
  logic [SW-1:0]        head_slot, tail_slot, cursor;
  logic [SW-1:0]        rd_next, rd_prev, fr_slot;
  logic [DATA_BITS-1:0] rd_val;
  status_t              pend_status;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op  <= op_t'(operation);
      val <= DATA_BITS'(value);
      pos <= position;
    end
    if (cmd.rd_cursor) begin
      rd_next <= nmem[cursor];
      rd_prev <= pmem[cursor];
      rd_val  <= vmem[cursor];
    end
    fr_slot <= fmem[SW'(free_top - CW'(1))];
  end

  // slot handed out on insert
  logic [SW-1:0] new_slot;
  assign new_slot = (free_top != '0) ? fr_slot : SW'(fresh_next);

  // insert neighbors: a before new, b after new
  logic [SW-1:0] ia, ib;
  always_comb begin
    if (cmd.ins_end) begin
      ia = tail_slot;
      ib = head_slot;
    end else begin
      ia = cursor;
      ib = rd_next;
    end
  end

  // decide phase also records status
  always_ff @(posedge clk) begin
    if (rst) begin
      free_top    <= '0;
      fresh_next  <= '0;
      head_slot   <= '0;
      tail_slot   <= '0;
      count       <= '0;
      pend_status <= ST_OK;
    end else begin
      if (cmd.walk_start) pend_status <= cmd.emit_status;
      if (cmd.do_insert) begin
        if (free_top != '0) free_top <= free_top - CW'(1);
        else fresh_next <= fresh_next + CW'(1);
        count <= count + CW'(1);
        if (count == '0) begin
          head_slot <= new_slot;
          tail_slot <= new_slot;
        end else if (cmd.ins_end) begin
          if (cmd.ins_head) head_slot <= new_slot;
          else tail_slot <= new_slot;
        end
      end
      if (cmd.do_unlink) begin
        count <= count - CW'(1);
        if (free_top < CW'(CAPACITY)) free_top <= free_top + CW'(1);
        if (count == CW'(1)) begin
          head_slot <= '0;
          tail_slot <= '0;
        end else begin
          if (cursor == head_slot) head_slot <= rd_next;
          if (cursor == tail_slot) tail_slot <= rd_prev;
        end
      end
    end
  end

  // memory writes: two link writes per memory happen in the same cycle on
  // distinct entries, so each link array takes two write ports here
  always_ff @(posedge clk) begin
    if (cmd.do_insert) begin
      vmem[new_slot] <= val;
      if (count == '0) begin
        nmem[new_slot] <= new_slot;
        pmem[new_slot] <= new_slot;
      end else begin
        nmem[new_slot] <= ib;
        pmem[new_slot] <= ia;
        nmem[ia]       <= new_slot;
        pmem[ib]       <= new_slot;
      end
    end
    if (cmd.do_unlink) begin
      if (free_top < CW'(CAPACITY)) fmem[SW'(free_top)] <= cursor;
      if (count != CW'(1)) begin
        nmem[rd_prev] <= rd_next;
        pmem[rd_next] <= rd_prev;
      end
    end
  end

  // cursor starts at head or tail and follows the registered next link
  always_ff @(posedge clk) begin
    if (cmd.walk_start) cursor <= cmd.sel_tail ? tail_slot : head_slot;
    else if (cmd.walk_step) cursor <= rd_next;
  end

  // result register
  logic [ValueBits-1:0] ext_val;
  assign ext_val = ValueBits'($signed(rd_val));

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.emit) begin
      status        <= cmd.emit_dump ? ST_OK : pend_status;
      element_value <= cmd.emit_dump ? ext_val : '0;
      list_length   <= LengthBits'(count);
      last_result   <= cmd.emit_last;
    end
  end

  assign sts.op       = op;
  assign sts.pos      = pos;
  assign sts.count    = LengthBits'(count);
  assign sts.full     = (count >= CW'(CAPACITY));
  assign sts.out_busy = out_valid && !out_ready;
endmodule

FILE: rtl/circular_list_engine.sv
// ----------------------------------------------------------------------------
// circular_list_engine
// Circular doubly linked list of signed words in a fixed slot pool.
// ----------------------------------------------------------------------------
// One request at a time. An end insert links the new slot straight from the
// head and tail; an end delete reads the end slot's links, then unlinks it. A
// positional request walks the next links from the head, one registered
// memory read per link, before it inserts or unlinks. A dump reads and emits
// each element in turn, one result per element. A stalled result adds its
// stall. No clearing pass after reset.
module circular_list_engine #(
  parameter int CAPACITY  = cle_pkg::CapacityDefault,
  parameter int DATA_BITS = cle_pkg::DataBitsDefault
) (
  input logic clk,
  input logic rst,
  cle_req_if.sink   req,
  cle_rsp_if.source rsp
);
  import cle_pkg::*;

  cle_cmd_t cmd;
  cle_sts_t sts;

  cle_ctrl u_ctrl (
    .clk, .rst,
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts, .cmd
  );

  cle_datapath #(.CAPACITY(CAPACITY), .DATA_BITS(DATA_BITS)) u_dp (
    .clk, .rst,
    .operation     (req.operation),
    .value         (req.value),
    .position      (req.position),
    .cmd, .sts,
    .out_valid     (rsp.valid),
    .out_ready     (rsp.ready),
    .status        (rsp.status),
    .element_value (rsp.element_value),
    .list_length   (rsp.list_length),
    .last_result   (rsp.last_result)
  );
endmodule

FILE: rtl/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port level checks of the circular list engine.
// ----------------------------------------------------------------------------
module cle_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic [31:0] element_value,
  input logic       last_result
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(element_value))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != 2'd0 |-> element_value == 32'd0 && last_result)
    else $error("error result with data");
endmodule

bind circular_list_engine cle_checker u_chk (
  .clk, .rst,
  .req_valid (req.valid), .req_ready (req.ready),
  .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
  .status (rsp.status), .element_value (rsp.element_value),
  .last_result (rsp.last_result)
);
